[design/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Short forms for the concurrent checks used in the design.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/tql_pkg.sv]
// ---------------------------------------------------------------------------
// tql_pkg
// Shared types, widths and constants of the Q-learning step core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tql_pkg;

   localparam int NUM_STATES_DEF  = 5;
   localparam int NUM_ACTIONS_DEF = 10;
   localparam int SAVE_PERIOD_DEF = 10;

   localparam int Q_W      = 32;
   localparam int FRAC_W   = 16;
   localparam int LEVEL_W  = 16;
   localparam int PCT_W    = 15;
   localparam int DRAW_W   = 7;
   localparam int RND_W    = 4;
   localparam int STATE_W  = 3;
   localparam int ACTION_W = 4;
   localparam int RWD_W    = 17;
   localparam int RWD_X_W  = 24;

   // Shared multiplier: signed A times unsigned B.
   localparam int MUL_A_W = 35;
   localparam int MUL_B_W = 18;
   localparam int PROD_W  = MUL_A_W + MUL_B_W + 1;

   localparam logic [PCT_W-1:0] PCT_FULL  = 15'd25600;
   localparam int               BIN_WIDTH = 100;

   // Reward is floor((64*num + 125) / 250), done as a reciprocal product.
   localparam logic [RWD_X_W-1:0] RWD_BIAS  = 24'd125;
   localparam logic [MUL_B_W-1:0] RWD_RECIP = 18'd134217;
   localparam int                 RWD_SHIFT = 25;
   localparam logic [RWD_X_W-1:0] RWD_DIV   = 24'd250;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [2:0] CSR_LEARN_ENABLE    = 3'd0;
   localparam logic [2:0] CSR_LEARNING_RATE   = 3'd1;
   localparam logic [2:0] CSR_DISCOUNT_FACTOR = 3'd2;
   localparam logic [2:0] CSR_EXPLORE_DECAY   = 3'd3;
   localparam logic [2:0] CSR_EXPLORE_FLOOR   = 3'd4;
   localparam logic [2:0] CSR_EXPLORE_START   = 3'd5;

   localparam logic        ENABLE_RST = 1'b1;
   localparam logic [15:0] ALPHA_RST  = 16'd655;
   localparam logic [15:0] GAMMA_RST  = 16'd58982;
   localparam logic [15:0] DECAY_RST  = 16'd65208;
   localparam logic [15:0] FLOOR_RST  = 16'd655;
   localparam logic [15:0] START_RST  = 16'd6554;

   localparam logic OP_LEARN = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ZERO,
      ST_SCAN,
      ST_GAMMA,
      ST_TARGET,
      ST_ALPHA,
      ST_UPDATE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      MUL_REWARD,
      MUL_GAMMA,
      MUL_ALPHA,
      MUL_DECAY
   } mul_op_type;

   typedef struct packed {
      logic       go;
      mul_op_type op;
   } mul_req_type;

endpackage

[design/tql_ram.sv]
// ---------------------------------------------------------------------------
// tql_ram
// Generic memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tql_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 50
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/tql_mul.sv]
// ---------------------------------------------------------------------------
// tql_mul
// Shared multiplier with operand selection and a registered product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tql_mul (
   input  logic                              clock,
   input  tql_pkg::mul_req_type              req,
   input  logic [tql_pkg::RWD_X_W-1:0]       reward_x,
   input  logic signed [tql_pkg::Q_W-1:0]    max_q,
   input  logic signed [tql_pkg::MUL_A_W-1:0] error,
   input  logic [15:0]                       rate,
   input  logic [15:0]                       gamma,
   input  logic [15:0]                       alpha,
   input  logic [15:0]                       decay,
   output logic signed [tql_pkg::PROD_W-1:0] product
);

   logic signed [tql_pkg::MUL_A_W-1:0] a_sel;
   logic        [tql_pkg::MUL_B_W-1:0] b_sel;
   logic signed [tql_pkg::MUL_B_W:0]   b_signed;
   logic signed [tql_pkg::PROD_W-1:0]  prod_ff;
   logic signed [tql_pkg::PROD_W-1:0]  prod_in;

   always_comb begin
      unique case (req.op)
         tql_pkg::MUL_REWARD: begin
            a_sel = $signed(tql_pkg::MUL_A_W'(reward_x));
            b_sel = tql_pkg::RWD_RECIP;
         end
         tql_pkg::MUL_GAMMA: begin
            a_sel = tql_pkg::MUL_A_W'(max_q);
            b_sel = tql_pkg::MUL_B_W'(gamma);
         end
         tql_pkg::MUL_ALPHA: begin
            a_sel = error;
            b_sel = tql_pkg::MUL_B_W'(alpha);
         end
         tql_pkg::MUL_DECAY: begin
            a_sel = $signed(tql_pkg::MUL_A_W'(rate));
            b_sel = tql_pkg::MUL_B_W'(decay);
         end
         default: begin
            a_sel = '0;
            b_sel = '0;
         end
      endcase
      b_signed = $signed({1'b0, b_sel});
      prod_in  = a_sel * b_signed;
   end

   always_ff @(posedge clock) begin
      if (req.go) begin
         prod_ff <= prod_in;
      end
   end

   assign product = prod_ff;

endmodule

[design/tabular_q_learning_step_core.sv]
// ---------------------------------------------------------------------------
// tabular_q_learning_step_core
// Q-learning step with epsilon-greedy action choice over a table in memory.
// ---------------------------------------------------------------------------
//
//   channel   ports               handshake
//   -------   -----------------   -------------------------------------------
//   request   start, req_*        taken at a clock edge with start=1, busy=0
//   result    rsp_valid, rsp_*    one-cycle strobe, cannot be held off
//   config    csr_p*              APB write at psel&penable&pwrite, pready=1
//
// A learn request keeps busy high for one pass of the row through the read
// port of the table memory, then four steps through the shared multiplier
// and a final bookkeeping step. The first learn request that touches a row
// after reset or after a clear first writes zeros across all of that row.
// Clear requests and learn requests while learning is disabled finish at once;
// busy stays low and the result strobe follows in the next cycle.
// Reset is synchronous and leaves every row marked empty; nothing stalls on the
// result side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tabular_q_learning_step_core #(
   parameter int NUM_STATES  = tql_pkg::NUM_STATES_DEF,
   parameter int NUM_ACTIONS = tql_pkg::NUM_ACTIONS_DEF,
   parameter int SAVE_PERIOD = tql_pkg::SAVE_PERIOD_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              start,
   output logic                              busy,
   input  logic                              req_operation,
   input  logic [tql_pkg::LEVEL_W-1:0]       req_pollution_level,
   input  logic [tql_pkg::PCT_W-1:0]         req_system_efficiency,
   input  logic [tql_pkg::PCT_W-1:0]         req_energy_usage,
   input  logic [tql_pkg::PCT_W-1:0]         req_system_health,
   input  logic [tql_pkg::DRAW_W-1:0]        req_explore_draw,
   input  logic [tql_pkg::RND_W-1:0]         req_random_action,

   output logic                              rsp_valid,
   output logic [tql_pkg::STATE_W-1:0]       rsp_state_index,
   output logic [tql_pkg::ACTION_W-1:0]      rsp_chosen_action,
   output logic                              rsp_explored,
   output logic [tql_pkg::RWD_W-1:0]         rsp_reward_value,
   output logic signed [tql_pkg::Q_W-1:0]    rsp_new_q_value,
   output logic                              rsp_save_due,
   output logic                              rsp_updated,

   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [tql_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [tql_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [tql_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   localparam int DEPTH  = NUM_STATES * NUM_ACTIONS;
   localparam int AW     = $clog2(DEPTH);
   localparam int ST_W   = $clog2(NUM_STATES);
   localparam int ACT_W  = $clog2(NUM_ACTIONS);
   localparam int CNT_W  = $clog2(NUM_ACTIONS + 1);
   localparam int PH_W   = (SAVE_PERIOD > 1) ? $clog2(SAVE_PERIOD) : 1;
   localparam int NQ_W   = 40;
   localparam int MOD_W  = 6;

   // Configuration registers.
   logic        enable_ff;
   logic [15:0] alpha_ff;
   logic [15:0] gamma_ff;
   logic [15:0] decay_ff;
   logic [15:0] floor_ff;
   logic [15:0] start_rate_ff;
   logic        csr_write;
   logic [2:0]  csr_index;

   // Control state.
   tql_pkg::state_type      state_ff, state_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [NUM_STATES-1:0]   row_valid_ff, row_valid_in;
   logic [15:0]             rate_ff, rate_in;
   logic [31:0]             count_ff, count_in;
   logic [PH_W-1:0]         phase_ff, phase_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // Per-request payload.
   logic [ST_W-1:0]                   st_ff, st_in;
   logic [AW-1:0]                     base_ff, base_in;
   logic [tql_pkg::RWD_X_W-1:0]       x_ff, x_in;
   logic                              explored_ff, explored_in;
   logic [ACT_W-1:0]                  rnd_ff, rnd_in;
   logic [tql_pkg::RWD_W-1:0]         reward_ff, reward_in;
   logic signed [tql_pkg::Q_W-1:0]    best_ff, best_in;
   logic [ACT_W-1:0]                  arg_ff, arg_in;
   logic signed [tql_pkg::Q_W-1:0]    sel_ff, sel_in;
   logic signed [tql_pkg::Q_W-1:0]    qsa_ff, qsa_in;
   logic [ACT_W-1:0]                  action_ff, action_in;
   logic signed [tql_pkg::MUL_A_W-1:0] err_ff, err_in;

   // Result registers.
   logic [tql_pkg::STATE_W-1:0]       rsp_state_ff, rsp_state_in;
   logic [tql_pkg::ACTION_W-1:0]      rsp_action_ff, rsp_action_in;
   logic                              rsp_explored_ff, rsp_explored_in;
   logic [tql_pkg::RWD_W-1:0]         rsp_reward_ff, rsp_reward_in;
   logic signed [tql_pkg::Q_W-1:0]    rsp_q_ff, rsp_q_in;
   logic                              rsp_save_ff, rsp_save_in;
   logic                              rsp_updated_ff, rsp_updated_in;

   // Request decode, plain logic on the request ports, the rate and busy.
   logic                       accept;
   logic [tql_pkg::PCT_W-1:0]  e_sat, u_sat, h_sat;
   logic [17:0]                num;
   logic [ST_W-1:0]            st_calc;
   logic [MOD_W-1:0]           rnd_mod;
   logic [22:0]                draw_scaled;
   logic [22:0]                rate_scaled;

   // Datapath helpers.
   tql_pkg::mul_req_type               mul_req;
   logic signed [tql_pkg::PROD_W-1:0]  product;
   logic                               ram_wr_en;
   logic [AW-1:0]                      ram_wr_addr;
   logic [tql_pkg::Q_W-1:0]            ram_wr_data;
   logic                               ram_rd_en;
   logic [AW-1:0]                      ram_rd_addr;
   logic [tql_pkg::Q_W-1:0]            ram_rd_data;
   logic signed [tql_pkg::Q_W-1:0]     rd_value;
   logic [ACT_W-1:0]                   scan_idx;
   logic [tql_pkg::RWD_W-1:0]          q0;
   logic [24:0]                        q0_times;
   logic [tql_pkg::RWD_X_W-1:0]        rwd_rem;
   logic signed [tql_pkg::MUL_A_W-1:0] scaled_gamma;
   logic signed [NQ_W-1:0]             nq_wide;
   logic [NQ_W-tql_pkg::Q_W:0]         nq_top;
   logic signed [tql_pkg::Q_W-1:0]     nq_sat;
   logic [15:0]                        decayed;
   logic [PH_W-1:0]                    phase_next;

   // -----------------------------------------------------------------------
   // Configuration port. Register i sits at byte address 4*i; pready is tied
   // high so every write completes in its access cycle.
   // -----------------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= tql_pkg::ENABLE_RST;
         alpha_ff      <= tql_pkg::ALPHA_RST;
         gamma_ff      <= tql_pkg::GAMMA_RST;
         decay_ff      <= tql_pkg::DECAY_RST;
         floor_ff      <= tql_pkg::FLOOR_RST;
         start_rate_ff <= tql_pkg::START_RST;
      end else if (csr_write) begin
         unique case (csr_index)
            tql_pkg::CSR_LEARN_ENABLE:    enable_ff     <= csr_pwdata[0];
            tql_pkg::CSR_LEARNING_RATE:   alpha_ff      <= csr_pwdata[15:0];
            tql_pkg::CSR_DISCOUNT_FACTOR: gamma_ff      <= csr_pwdata[15:0];
            tql_pkg::CSR_EXPLORE_DECAY:   decay_ff      <= csr_pwdata[15:0];
            tql_pkg::CSR_EXPLORE_FLOOR:   floor_ff      <= csr_pwdata[15:0];
            tql_pkg::CSR_EXPLORE_START:   start_rate_ff <= csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         tql_pkg::CSR_LEARN_ENABLE:    csr_prdata = tql_pkg::CSR_DATA_W'(enable_ff);
         tql_pkg::CSR_LEARNING_RATE:   csr_prdata = tql_pkg::CSR_DATA_W'(alpha_ff);
         tql_pkg::CSR_DISCOUNT_FACTOR: csr_prdata = tql_pkg::CSR_DATA_W'(gamma_ff);
         tql_pkg::CSR_EXPLORE_DECAY:   csr_prdata = tql_pkg::CSR_DATA_W'(decay_ff);
         tql_pkg::CSR_EXPLORE_FLOOR:   csr_prdata = tql_pkg::CSR_DATA_W'(floor_ff);
         tql_pkg::CSR_EXPLORE_START:   csr_prdata = tql_pkg::CSR_DATA_W'(start_rate_ff);
         default:                      csr_prdata = '0;
      endcase
   end

   // -----------------------------------------------------------------------
   // Request decode. The percentages saturate at 100 percent, the pollution
   // level is binned by comparing against each threshold, and the random
   // action is reduced modulo the action count by repeated subtraction (the
   // draw is only four bits, so eight steps always suffice).
   // -----------------------------------------------------------------------
   assign busy   = (state_ff != tql_pkg::ST_IDLE);
   assign accept = start & ~busy;

   always_comb begin
      e_sat = (req_system_efficiency > tql_pkg::PCT_FULL) ? tql_pkg::PCT_FULL
                                                          : req_system_efficiency;
      u_sat = (req_energy_usage > tql_pkg::PCT_FULL) ? tql_pkg::PCT_FULL
                                                     : req_energy_usage;
      h_sat = (req_system_health > tql_pkg::PCT_FULL) ? tql_pkg::PCT_FULL
                                                      : req_system_health;

      // Weighted sum 5e + 3(100% - u) + 2h, at most 256000.
      num = 18'({e_sat, 2'b00}) + 18'(e_sat)
          + 18'({tql_pkg::PCT_FULL - u_sat, 1'b0}) + 18'(tql_pkg::PCT_FULL - u_sat)
          + 18'({h_sat, 1'b0});

      st_calc = '0;
      for (int k = 1; k < NUM_STATES; k++) begin
         if (req_pollution_level >= tql_pkg::LEVEL_W'(k * tql_pkg::BIN_WIDTH)) begin
            st_calc = ST_W'(k);
         end
      end

      rnd_mod = MOD_W'(req_random_action);
      for (int k = 0; k < 8; k++) begin
         if (rnd_mod >= MOD_W'(NUM_ACTIONS)) begin
            rnd_mod = rnd_mod - MOD_W'(NUM_ACTIONS);
         end
      end

      // Explore when draw * 65536 < rate * 100, using the rate before decay.
      draw_scaled = {req_explore_draw, 16'b0};
      rate_scaled = 23'(rate_ff) * 23'(100);
   end

   // -----------------------------------------------------------------------
   // Datapath helpers shared by the sequencer.
   // -----------------------------------------------------------------------
   always_comb begin
      rd_value = $signed(ram_rd_data);
      scan_idx = ACT_W'(cnt_ff - CNT_W'(1));

      // Reward correction: the reciprocal product is the quotient or one less.
      q0       = product[tql_pkg::RWD_SHIFT +: tql_pkg::RWD_W];
      q0_times = {q0, 8'b0} - 25'({q0, 2'b0}) - 25'({q0, 1'b0});
      rwd_rem  = x_ff - q0_times[tql_pkg::RWD_X_W-1:0];

      // gamma * maxQ and alpha * error, floored by the arithmetic shift.
      scaled_gamma = tql_pkg::MUL_A_W'(product >>> tql_pkg::FRAC_W);
      nq_wide      = NQ_W'(qsa_ff) + NQ_W'(product >>> tql_pkg::FRAC_W);
      nq_top       = nq_wide[NQ_W-1:tql_pkg::Q_W-1];
      if (nq_top != '0 && nq_top != '1) begin
         nq_sat = nq_wide[NQ_W-1] ? {1'b1, {(tql_pkg::Q_W-1){1'b0}}}
                                  : {1'b0, {(tql_pkg::Q_W-1){1'b1}}};
      end else begin
         nq_sat = nq_wide[tql_pkg::Q_W-1:0];
      end

      decayed = product[31:16];

      // Save phase tracks count modulo the period; a counter wrap restarts it.
      if (count_ff == '1 || phase_ff == PH_W'(SAVE_PERIOD - 1)) begin
         phase_next = '0;
      end else begin
         phase_next = phase_ff + PH_W'(1);
      end
   end

   // -----------------------------------------------------------------------
   // Sequencer.
   //   IDLE   : take a request; clears and disabled learns finish here.
   //   ZERO   : first use of a row since clear, write zeros across it.
   //   SCAN   : read the row, track maximum, argmax and the explored entry.
   //            The reward product is formed and corrected during the scan.
   //   GAMMA  : gamma * maxQ on the multiplier.
   //   TARGET : error = reward + gamma*maxQ - Q(s,a).
   //   ALPHA  : alpha * error on the multiplier.
   //   UPDATE : saturate and write the entry back; start the rate decay.
   //   FINISH : floor the rate, count the iteration and post the result.
   // -----------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      row_valid_in = row_valid_ff;
      rate_in      = rate_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      rsp_valid_in = 1'b0;

      st_in       = st_ff;
      base_in     = base_ff;
      x_in        = x_ff;
      explored_in = explored_ff;
      rnd_in      = rnd_ff;
      reward_in   = reward_ff;
      best_in     = best_ff;
      arg_in      = arg_ff;
      sel_in      = sel_ff;
      qsa_in      = qsa_ff;
      action_in   = action_ff;
      err_in      = err_ff;

      rsp_state_in    = rsp_state_ff;
      rsp_action_in   = rsp_action_ff;
      rsp_explored_in = rsp_explored_ff;
      rsp_reward_in   = rsp_reward_ff;
      rsp_q_in        = rsp_q_ff;
      rsp_save_in     = rsp_save_ff;
      rsp_updated_in  = rsp_updated_ff;

      mul_req.go  = 1'b0;
      mul_req.op  = tql_pkg::MUL_REWARD;
      ram_wr_en   = 1'b0;
      ram_wr_addr = base_ff + AW'(cnt_ff);
      ram_wr_data = '0;
      ram_rd_en   = 1'b0;
      ram_rd_addr = base_ff + AW'(cnt_ff);

      unique case (state_ff)
         tql_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_operation == tql_pkg::OP_CLEAR) begin
                  row_valid_in    = '0;
                  count_in        = '0;
                  phase_in        = '0;
                  rate_in         = start_rate_ff;
                  rsp_valid_in    = 1'b1;
                  rsp_state_in    = '0;
                  rsp_action_in   = '0;
                  rsp_explored_in = 1'b0;
                  rsp_reward_in   = '0;
                  rsp_q_in        = '0;
                  rsp_save_in     = 1'b0;
                  rsp_updated_in  = 1'b1;
               end else if (!enable_ff) begin
                  rsp_valid_in    = 1'b1;
                  rsp_state_in    = '0;
                  rsp_action_in   = '0;
                  rsp_explored_in = 1'b0;
                  rsp_reward_in   = '0;
                  rsp_q_in        = '0;
                  rsp_save_in     = 1'b0;
                  rsp_updated_in  = 1'b0;
               end else begin
                  st_in       = st_calc;
                  base_in     = AW'(st_calc * NUM_ACTIONS);
                  x_in        = {num, 6'b0} + tql_pkg::RWD_BIAS;
                  explored_in = (draw_scaled < rate_scaled);
                  rnd_in      = ACT_W'(rnd_mod);
                  cnt_in      = '0;
                  state_in    = row_valid_ff[st_calc] ? tql_pkg::ST_SCAN
                                                      : tql_pkg::ST_ZERO;
               end
            end
         end

         tql_pkg::ST_ZERO: begin
            ram_wr_en = 1'b1;
            if (cnt_ff == CNT_W'(NUM_ACTIONS - 1)) begin
               row_valid_in[st_ff] = 1'b1;
               cnt_in              = '0;
               state_in            = tql_pkg::ST_SCAN;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         tql_pkg::ST_SCAN: begin
            if (cnt_ff < CNT_W'(NUM_ACTIONS)) begin
               ram_rd_en = 1'b1;
            end
            if (cnt_ff == '0) begin
               mul_req.go = 1'b1;
               mul_req.op = tql_pkg::MUL_REWARD;
            end
            if (cnt_ff == CNT_W'(1)) begin
               reward_in = (rwd_rem >= tql_pkg::RWD_DIV) ? q0 + tql_pkg::RWD_W'(1) : q0;
            end
            if (cnt_ff != '0) begin
               // Strictly greater keeps the lowest index among equal maxima.
               if (cnt_ff == CNT_W'(1) || rd_value > best_ff) begin
                  best_in = rd_value;
                  arg_in  = scan_idx;
               end
               if (scan_idx == rnd_ff) begin
                  sel_in = rd_value;
               end
            end
            if (cnt_ff == CNT_W'(NUM_ACTIONS)) begin
               state_in = tql_pkg::ST_GAMMA;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end

         tql_pkg::ST_GAMMA: begin
            mul_req.go = 1'b1;
            mul_req.op = tql_pkg::MUL_GAMMA;
            qsa_in     = explored_ff ? sel_ff : best_ff;
            action_in  = explored_ff ? rnd_ff : arg_ff;
            state_in   = tql_pkg::ST_TARGET;
         end

         tql_pkg::ST_TARGET: begin
            err_in   = $signed(tql_pkg::MUL_A_W'(reward_ff)) + scaled_gamma
                     - tql_pkg::MUL_A_W'(qsa_ff);
            state_in = tql_pkg::ST_ALPHA;
         end

         tql_pkg::ST_ALPHA: begin
            mul_req.go = 1'b1;
            mul_req.op = tql_pkg::MUL_ALPHA;
            state_in   = tql_pkg::ST_UPDATE;
         end

         tql_pkg::ST_UPDATE: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = base_ff + AW'(action_ff);
            ram_wr_data = nq_sat;
            rsp_q_in    = nq_sat;
            mul_req.go  = 1'b1;
            mul_req.op  = tql_pkg::MUL_DECAY;
            state_in    = tql_pkg::ST_FINISH;
         end

         tql_pkg::ST_FINISH: begin
            rate_in         = (decayed < floor_ff) ? floor_ff : decayed;
            count_in        = count_ff + 32'd1;
            phase_in        = phase_next;
            rsp_valid_in    = 1'b1;
            rsp_state_in    = tql_pkg::STATE_W'(st_ff);
            rsp_action_in   = tql_pkg::ACTION_W'(action_ff);
            rsp_explored_in = explored_ff;
            rsp_reward_in   = reward_ff;
            rsp_save_in     = (phase_next == '0);
            rsp_updated_in  = 1'b1;
            state_in        = tql_pkg::ST_IDLE;
         end

         default: begin
            state_in = tql_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tql_pkg::ST_IDLE;
         cnt_ff       <= '0;
         row_valid_ff <= '0;
         rate_ff      <= tql_pkg::START_RST;
         count_ff     <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         row_valid_ff <= row_valid_in;
         rate_ff      <= rate_in;
         count_ff     <= count_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      st_ff           <= st_in;
      base_ff         <= base_in;
      x_ff            <= x_in;
      explored_ff     <= explored_in;
      rnd_ff          <= rnd_in;
      reward_ff       <= reward_in;
      best_ff         <= best_in;
      arg_ff          <= arg_in;
      sel_ff          <= sel_in;
      qsa_ff          <= qsa_in;
      action_ff       <= action_in;
      err_ff          <= err_in;
      rsp_state_ff    <= rsp_state_in;
      rsp_action_ff   <= rsp_action_in;
      rsp_explored_ff <= rsp_explored_in;
      rsp_reward_ff   <= rsp_reward_in;
      rsp_q_ff        <= rsp_q_in;
      rsp_save_ff     <= rsp_save_in;
      rsp_updated_ff  <= rsp_updated_in;
   end

   // -----------------------------------------------------------------------
   // Table memory and the shared multiplier.
   // -----------------------------------------------------------------------
   tql_ram #(
      .WIDTH (tql_pkg::Q_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   tql_mul u_mul (
      .clock    (clock),
      .req      (mul_req),
      .reward_x (x_ff),
      .max_q    (best_ff),
      .error    (err_ff),
      .rate     (rate_ff),
      .gamma    (gamma_ff),
      .alpha    (alpha_ff),
      .decay    (decay_ff),
      .product  (product)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_state_index   = rsp_state_ff;
   assign rsp_chosen_action = rsp_action_ff;
   assign rsp_explored      = rsp_explored_ff;
   assign rsp_reward_value  = rsp_reward_ff;
   assign rsp_new_q_value   = rsp_q_ff;
   assign rsp_save_due      = rsp_save_ff;
   assign rsp_updated       = rsp_updated_ff;

   // -----------------------------------------------------------------------
   // Checks.
   // -----------------------------------------------------------------------
   `ASSERT_IMPLY(a_scan_row_valid, clock, reset, state_ff == tql_pkg::ST_SCAN,
                 row_valid_ff[st_ff], "row scanned before it was zeroed")
   `ASSERT_NEXT(a_finish_posts, clock, reset, state_ff == tql_pkg::ST_FINISH,
                rsp_valid_ff && rsp_updated_ff, "finished step posted no result")
   `ASSERT_IMPLY(a_result_source, clock, reset, rsp_valid_ff,
                 $past(state_ff) == tql_pkg::ST_FINISH || $past(accept),
                 "result strobe without a finished request")
   `ASSERT_NEXT(a_clear_rows, clock, reset,
                accept && req_operation == tql_pkg::OP_CLEAR,
                row_valid_ff == '0 && count_ff == '0, "clear left table state")

endmodule

[dv/tabular_q_learning_step_core_tb.sv]
// ---------------------------------------------------------------------------
// tabular_q_learning_step_core_tb
// Self-checking bench for the Q-learning step core. A tracker keeps its own
// Q table, exploration rate and step counter and predicts every response.
// A short directed run comes first, then six random phases with different
// register settings and sender pacing.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package tql_step_check_pkg;
   import tql_pkg::*;

   typedef struct {
      logic               operation;
      logic [LEVEL_W-1:0] level;
      logic [PCT_W-1:0]   efficiency;
      logic [PCT_W-1:0]   energy;
      logic [PCT_W-1:0]   health;
      logic [DRAW_W-1:0]  draw;
      logic [RND_W-1:0]   rnd_action;
   } step_request_type;

   typedef struct {
      logic [STATE_W-1:0]     state_index;
      logic [ACTION_W-1:0]    action;
      logic                   explored;
      logic [RWD_W-1:0]       reward;
      logic signed [Q_W-1:0]  q_value;
      logic                   save_due;
      logic                   updated;
   } step_result_type;

   class q_learning_tracker;
      logic signed [Q_W-1:0] q_row [NUM_STATES_DEF][NUM_ACTIONS_DEF];
      logic [15:0]           explore_rate;
      logic [31:0]           steps_done;
      logic                  learn_on;
      logic [15:0]           alpha;
      logic [15:0]           gamma;
      logic [15:0]           decay;
      logic [15:0]           rate_floor;
      logic [15:0]           rate_start;
      step_result_type       expected_steps[$];
      int                    mismatches;

      function new();
         learn_on   = ENABLE_RST;
         alpha      = ALPHA_RST;
         gamma      = GAMMA_RST;
         decay      = DECAY_RST;
         rate_floor = FLOOR_RST;
         rate_start = START_RST;
         mismatches = 0;
         clear_table();
      endfunction

      function void clear_table();
         foreach (q_row[s, a]) q_row[s][a] = '0;
         steps_done   = '0;
         explore_rate = rate_start;
      endfunction

      function void set_register(logic [2:0] idx, logic [31:0] value);
         case (idx)
            CSR_LEARN_ENABLE:    learn_on   = value[0];
            CSR_LEARNING_RATE:   alpha      = value[15:0];
            CSR_DISCOUNT_FACTOR: gamma      = value[15:0];
            CSR_EXPLORE_DECAY:   decay      = value[15:0];
            CSR_EXPLORE_FLOOR:   rate_floor = value[15:0];
            CSR_EXPLORE_START:   rate_start = value[15:0];
            default: ;
         endcase
      endfunction

      function longint clip_pct(logic [PCT_W-1:0] v);
         longint r;
         r = longint'(v);
         if (r > PCT_FULL) r = PCT_FULL;
         return r;
      endfunction

      // Product of a Q16 fraction and a signed value, rounded toward minus infinity.
      function longint scale_q16(longint a, longint b);
         return (a * b) >>> FRAC_W;
      endfunction

      function step_result_type predict_step(step_request_type rq);
         step_result_type res;
         longint       e, u, h, num, rwd, best, target, err, cur, nq, rate, draw_l;
         int           st, act;
         res = '{default: '0};
         if (rq.operation == OP_CLEAR) begin
            clear_table();
            res.updated = 1'b1;
            return res;
         end
         if (!learn_on) return res;

         e = clip_pct(rq.efficiency);
         u = clip_pct(rq.energy);
         h = clip_pct(rq.health);
         st = int'(rq.level) / BIN_WIDTH;
         if (st > NUM_STATES_DEF - 1) st = NUM_STATES_DEF - 1;

         num = 5 * e + 3 * (PCT_FULL - u) + 2 * h;
         rwd = (num * 65536 + 128000) / 256000;

         // Greedy pick is the lowest-index maximum; the maximum also feeds the target.
         best = longint'(q_row[st][0]);
         act  = 0;
         for (int a = 1; a < NUM_ACTIONS_DEF; a++) begin
            if (q_row[st][a] > best) begin
               best = longint'(q_row[st][a]);
               act  = a;
            end
         end
         draw_l = longint'(rq.draw);
         rate   = longint'(explore_rate);
         if (draw_l * 65536 < rate * 100) begin
            res.explored = 1'b1;
            act = int'(rq.rnd_action) % NUM_ACTIONS_DEF;
         end

         cur    = longint'(q_row[st][act]);
         target = rwd + scale_q16(best, gamma);
         err    = target - cur;
         nq     = cur + scale_q16(err, alpha);
         if (nq > 64'sd2147483647) nq = 64'sd2147483647;
         if (nq < -64'sd2147483648) nq = -64'sd2147483648;
         q_row[st][act] = nq[Q_W-1:0];

         rate = (rate * decay) >>> FRAC_W;
         if (rate < rate_floor) rate = rate_floor;
         explore_rate = rate[15:0];
         steps_done   = steps_done + 1;

         res.state_index = st[STATE_W-1:0];
         res.action      = act[ACTION_W-1:0];
         res.reward      = rwd[RWD_W-1:0];
         res.q_value     = nq[Q_W-1:0];
         res.save_due    = (steps_done % SAVE_PERIOD_DEF) == 0;
         res.updated     = 1'b1;
         return res;
      endfunction

      function void note_request(step_request_type rq);
         expected_steps.push_back(predict_step(rq));
      endfunction

      function int pending();
         return expected_steps.size();
      endfunction

      // One line per mismatch, and every one is counted.
      task flag_mismatch(string what, longint got_v, longint want_v);
         mismatches++;
         $display("%0t: mismatch in %s: got %0d, expected %0d", $realtime, what,
                  got_v, want_v);
      endtask

      task check_response(step_result_type got);
         step_result_type want;
         if (expected_steps.size() == 0) begin
            flag_mismatch("response with no request waiting", got.updated, 0);
            return;
         end
         want = expected_steps.pop_front();
         if (got.state_index !== want.state_index)
            flag_mismatch("state_index", got.state_index, want.state_index);
         if (got.action !== want.action)
            flag_mismatch("chosen_action", got.action, want.action);
         if (got.explored !== want.explored)
            flag_mismatch("explored", got.explored, want.explored);
         if (got.reward !== want.reward)
            flag_mismatch("reward_value", got.reward, want.reward);
         if (got.q_value !== want.q_value)
            flag_mismatch("new_q_value", got.q_value, want.q_value);
         if (got.save_due !== want.save_due)
            flag_mismatch("save_due", got.save_due, want.save_due);
         if (got.updated !== want.updated)
            flag_mismatch("updated", got.updated, want.updated);
      endtask
   endclass

endpackage

module tabular_q_learning_step_core_tb;
   import tql_pkg::*;
   import tql_step_check_pkg::*;

   // Cycles without any request or response before the run is declared hung.
   // Sender gaps are short random runs.
   localparam int HANG_LIMIT = 3000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  start                 = 1'b0;
   logic                  busy;
   logic                  req_operation         = OP_LEARN;
   logic [LEVEL_W-1:0]    req_pollution_level   = '0;
   logic [PCT_W-1:0]      req_system_efficiency = '0;
   logic [PCT_W-1:0]      req_energy_usage      = '0;
   logic [PCT_W-1:0]      req_system_health     = '0;
   logic [DRAW_W-1:0]     req_explore_draw      = '0;
   logic [RND_W-1:0]      req_random_action     = '0;

   logic                  rsp_valid;
   logic [STATE_W-1:0]    rsp_state_index;
   logic [ACTION_W-1:0]   rsp_chosen_action;
   logic                  rsp_explored;
   logic [RWD_W-1:0]      rsp_reward_value;
   logic signed [Q_W-1:0] rsp_new_q_value;
   logic                  rsp_save_due;
   logic                  rsp_updated;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   q_learning_tracker tracker = new();

   // Percent chance, per cycle, that the sender stays idle before a request.
   int sender_idle_pct = 0;
   int quiet_cycles    = 0;

   tabular_q_learning_step_core dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_operation         (req_operation),
      .req_pollution_level   (req_pollution_level),
      .req_system_efficiency (req_system_efficiency),
      .req_energy_usage      (req_energy_usage),
      .req_system_health     (req_system_health),
      .req_explore_draw      (req_explore_draw),
      .req_random_action     (req_random_action),
      .rsp_valid             (rsp_valid),
      .rsp_state_index       (rsp_state_index),
      .rsp_chosen_action     (rsp_chosen_action),
      .rsp_explored          (rsp_explored),
      .rsp_reward_value      (rsp_reward_value),
      .rsp_new_q_value       (rsp_new_q_value),
      .rsp_save_due          (rsp_save_due),
      .rsp_updated           (rsp_updated),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   always #5 clock = ~clock;

   // Monitor. Everything is sampled at the rising edge, so the values seen are
   // the ones that held during the cycle that this edge ends. A response is
   // checked before a request at the same edge is noted, because that response
   // can only belong to an earlier request.
   always @(posedge clock) begin
      step_result_type  got;
      step_request_type seen;
      if (!reset) begin
         if (rsp_valid) begin
            got.state_index = rsp_state_index;
            got.action      = rsp_chosen_action;
            got.explored    = rsp_explored;
            got.reward      = rsp_reward_value;
            got.q_value     = rsp_new_q_value;
            got.save_due    = rsp_save_due;
            got.updated     = rsp_updated;
            tracker.check_response(got);
         end
         if (start && !busy) begin
            seen.operation  = req_operation;
            seen.level      = req_pollution_level;
            seen.efficiency = req_system_efficiency;
            seen.energy     = req_energy_usage;
            seen.health     = req_system_health;
            seen.draw       = req_explore_draw;
            seen.rnd_action = req_random_action;
            tracker.note_request(seen);
         end
      end
   end

   // Watchdog: the count restarts whenever a request or a response moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= HANG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Drivers run at the falling edge and always return at a falling edge.
   // A request is presented, and start held, until a rising edge sees busy low.
   // Back-to-back requests keep start high and only swap the payload.
   task automatic issue_request(step_request_type rq);
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      req_operation         = rq.operation;
      req_pollution_level   = rq.level;
      req_system_efficiency = rq.efficiency;
      req_energy_usage      = rq.energy;
      req_system_health     = rq.health;
      req_explore_draw      = rq.draw;
      req_random_action     = rq.rnd_action;
      start                 = 1'b1;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic learn_step(int level, int eff, int nrg, int hlth, int draw, int act);
      step_request_type rq;
      rq.operation  = OP_LEARN;
      rq.level      = LEVEL_W'(level);
      rq.efficiency = PCT_W'(eff);
      rq.energy     = PCT_W'(nrg);
      rq.health     = PCT_W'(hlth);
      rq.draw       = DRAW_W'(draw);
      rq.rnd_action = RND_W'(act);
      issue_request(rq);
   endtask

   task automatic clear_step();
      step_request_type rq;
      rq.operation  = OP_CLEAR;
      rq.level      = LEVEL_W'($urandom_range(65535));
      rq.efficiency = PCT_W'($urandom_range(32767));
      rq.energy     = PCT_W'($urandom_range(32767));
      rq.health     = PCT_W'($urandom_range(32767));
      rq.draw       = DRAW_W'($urandom_range(127));
      rq.rnd_action = RND_W'($urandom_range(15));
      issue_request(rq);
   endtask

   // Holds the sender off until every predicted response has come back.
   task automatic wait_drained();
      start = 1'b0;
      while (tracker.pending() != 0 || busy) @(negedge clock);
   endtask

   // APB write: a setup cycle, then an access cycle that ends at the edge
   // where pready is seen high. The tracker takes the value at that edge.
   task automatic write_register(logic [2:0] idx, logic [31:0] value);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_register(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   // Setting 0 puts every register at its top, setting 1 at its bottom (with
   // learning still on), setting 2 draws random values. Random writes to four
   // of the registers carry junk in the upper half, which the block must drop.
   task automatic program_setting(int kind);
      logic [15:0] junk;
      junk = 16'($urandom_range(65535));
      case (kind)
         0: begin
            write_register(CSR_LEARN_ENABLE, 32'd1);
            write_register(CSR_LEARNING_RATE, 32'hFFFF);
            write_register(CSR_DISCOUNT_FACTOR, 32'hFFFF);
            write_register(CSR_EXPLORE_DECAY, 32'hFFFF);
            write_register(CSR_EXPLORE_FLOOR, 32'hFFFF);
            write_register(CSR_EXPLORE_START, 32'hFFFF);
         end
         1: begin
            write_register(CSR_LEARN_ENABLE, 32'd1);
            write_register(CSR_LEARNING_RATE, 32'd0);
            write_register(CSR_DISCOUNT_FACTOR, 32'd0);
            write_register(CSR_EXPLORE_DECAY, 32'd0);
            write_register(CSR_EXPLORE_FLOOR, 32'd0);
            write_register(CSR_EXPLORE_START, 32'd0);
         end
         default: begin
            write_register(CSR_LEARN_ENABLE, {junk[14:0], 17'd1});
            write_register(CSR_LEARNING_RATE, {junk, 16'($urandom_range(65535))});
            write_register(CSR_DISCOUNT_FACTOR, {16'd0, 16'($urandom_range(65535))});
            // Slow decay most of the time so that exploration lasts a while.
            write_register(CSR_EXPLORE_DECAY,
                           {junk, 16'($urandom_range(1) ? $urandom_range(50000, 65535)
                                                        : $urandom_range(65535))});
            write_register(CSR_EXPLORE_FLOOR, {16'd0, 16'($urandom_range(8000))});
            write_register(CSR_EXPLORE_START, {junk, 16'($urandom_range(65535))});
         end
      endcase
   endtask

   // Percentages mostly lie in range; some sit on the ends and some exceed 100%.
   function automatic logic [PCT_W-1:0] random_pct();
      case ($urandom_range(9))
         0:       return '0;
         1:       return PCT_FULL;
         2:       return PCT_W'($urandom_range(32767));
         default: return PCT_W'($urandom_range(25600));
      endcase
   endfunction

   function automatic step_request_type random_request();
      step_request_type rq;
      rq.operation  = ($urandom_range(99) < 3) ? OP_CLEAR : OP_LEARN;
      // Most levels fall in the five bins; the rest cover the whole field.
      rq.level      = LEVEL_W'(($urandom_range(4) == 0) ? $urandom_range(65535)
                                                       : $urandom_range(499));
      rq.efficiency = random_pct();
      rq.energy     = random_pct();
      rq.health     = random_pct();
      rq.draw       = DRAW_W'(($urandom_range(6) == 0) ? $urandom_range(127)
                                                      : $urandom_range(99));
      rq.rnd_action = RND_W'($urandom_range(15));
      return rq;
   endfunction

   initial begin
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed part, with the reset register values. It walks the bin
      // edges, the reward extremes, percentages above 100%, draws on both
      // sides of the exploration threshold and out-of-range random actions.
      learn_step(0,     0,     0,     0,     99,  0);
      learn_step(99,    25600, 0,     25600, 127, 0);
      learn_step(100,   32767, 32767, 32767, 100, 15);
      learn_step(199,   25601, 25600, 0,     11,  9);
      learn_step(200,   12800, 12800, 12800, 0,   15);
      learn_step(299,   1,     2,     3,     9,   10);
      learn_step(300,   25600, 0,     25600, 10,  9);
      learn_step(399,   7,     25599, 100,   50,  3);
      learn_step(400,   25600, 0,     25600, 99,  0);
      learn_step(65535, 32767, 0,     32767, 0,   9);
      learn_step(450,   25600, 0,     25600, 99,  0);
      learn_step(450,   25600, 0,     25600, 99,  0);
      learn_step(450,   0,     25600, 0,     99,  0);
      clear_step();
      learn_step(450,   25600, 0,     25600, 0,   1);

      // With learning off a learn request does nothing, but a clear still acts.
      wait_drained();
      write_register(CSR_LEARN_ENABLE, 32'd0);
      learn_step(250,   25600, 0,     25600, 0,   2);
      clear_step();
      learn_step(150,   100,   200,   300,   99,  4);
      wait_drained();
      write_register(CSR_LEARN_ENABLE, 32'd1);
      learn_step(150,   100,   200,   300,   99,  4);

      // Random phases: sender idle in 35% of cycles, then 81%, then never, for two
      // phases each, while the register settings run top, bottom and random in turn. Every
      // phase starts with a clear so that the new start rate is loaded.
      for (int phase = 0; phase < 6; phase++) begin
         sender_idle_pct = (phase < 2) ? 35 : (phase < 4) ? 81 : 0;
         wait_drained();
         program_setting(phase % 3);
         clear_step();
         for (int n = 0; n < 130; n++) begin
            if ($urandom_range(199) == 0) wait_drained();
            issue_request(random_request());
         end
      end

      wait_drained();
      repeat (40) @(posedge clock);
      if (tracker.pending() != 0)
         tracker.flag_mismatch("responses never seen", tracker.pending(), 0);
      if (tracker.mismatches == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/tql_pkg.sv
design/tql_ram.sv
design/tql_mul.sv
design/tabular_q_learning_step_core.sv
dv/tabular_q_learning_step_core_tb.sv
